// File: hdl/arcm_pkg.sv
package arcm_pkg;

   // defaults for the top-level parameters
   localparam int PALETTE_SIZE_DEFAULT = 10;
   localparam int SAMPLE_BITS_DEFAULT  = 16;

   // palette table depth and its index width
   localparam int TABLE_DEPTH = 32;
   localparam int ENTRY_BITS  = 5;

   // request codes
   localparam logic [1:0] REQ_CLEAR = 2'd0;
   localparam logic [1:0] REQ_WIDEN = 2'd1;
   localparam logic [1:0] REQ_MAP   = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] sample_value;
   } req_item_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       range_empty;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } color_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIVIDE,
      ST_BLEND
   } state_type;

   // palette bytes, floor(255 * c); unused entries read as zero
   function automatic color_type palette_entry(input logic [ENTRY_BITS-1:0] idx);
      color_type c;
      case (idx)
         5'd0:    c = '{8'd10,  8'd44,  8'd121, 8'd255};
         5'd1:    c = '{8'd19,  8'd88,  8'd133, 8'd255};
         5'd2:    c = '{8'd28,  8'd135, 8'd145, 8'd255};
         5'd3:    c = '{8'd4,   8'd213, 8'd15,  8'd255};
         5'd4:    c = '{8'd170, 8'd241, 8'd0,   8'd255};
         5'd5:    c = '{8'd251, 8'd248, 8'd3,   8'd255};
         5'd6:    c = '{8'd245, 8'd206, 8'd9,   8'd255};
         5'd7:    c = '{8'd226, 8'd135, 8'd31,  8'd255};
         5'd8:    c = '{8'd209, 8'd104, 8'd47,  8'd255};
         5'd9:    c = '{8'd194, 8'd82,  8'd59,  8'd255};
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

// File: hdl/auto_range_color_map.sv
// clear and widen requests give no transfer on rsp
// a map request passes the PREP, DIVIDE and BLEND states before its result is loaded,
// with the radix-2 divider producing one position bit per cycle; an empty range skips DIVIDE
// req_ready is low while a map is in work; a result waits in the output register
// a map must leave BLEND before another request is taken; clear and widen one per cycle while idle
// reset is synchronous and active high: range unset, no result pending, sequencer idle
module auto_range_color_map #(
   parameter int PALETTE_SIZE = arcm_pkg::PALETTE_SIZE_DEFAULT,
   parameter int SAMPLE_BITS  = arcm_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  arcm_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output arcm_pkg::rsp_item_type rsp_data
);

   // bits of PALETTE_SIZE - 1
   localparam int MUL_BITS = $clog2(PALETTE_SIZE);
   // position has 8 fraction bits and never exceeds (PALETTE_SIZE - 1) * 256
   localparam int QUO_BITS = $clog2((PALETTE_SIZE - 1) * 256 + 1);
   localparam int NUM_BITS = SAMPLE_BITS + MUL_BITS + 8;

   // sequencer
   arcm_pkg::state_type state_ff, state_in;

   // tracked range
   logic [SAMPLE_BITS-1:0] range_low_ff, range_low_in;
   logic [SAMPLE_BITS-1:0] range_high_ff, range_high_in;
   logic                   range_seen_ff, range_seen_in;

   // item in work
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                   empty_ff, empty_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   arcm_pkg::rsp_item_type rsp_data_ff, rsp_data_in;

   logic                   req_xfer;
   logic [SAMPLE_BITS-1:0] samp;
   logic [SAMPLE_BITS-1:0] clamped;
   logic [SAMPLE_BITS-1:0] diff;
   logic [SAMPLE_BITS-1:0] span;
   logic [NUM_BITS-1:0]    num;
   logic                   div_start;
   logic                   div_done;
   logic [QUO_BITS-1:0]    position;
   logic                   blend_load;
   arcm_pkg::rsp_item_type blend_out;

   // sample is used in its low SAMPLE_BITS bits
   assign samp     = SAMPLE_BITS'(req_data.sample_value);
   assign req_xfer = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         arcm_pkg::ST_IDLE: begin
            if (req_xfer && req_data.req_type == arcm_pkg::REQ_MAP) begin
               state_in = arcm_pkg::ST_PREP;
            end
         end
         arcm_pkg::ST_PREP: begin
            // an empty range skips the divider entirely
            state_in = empty_ff ? arcm_pkg::ST_BLEND : arcm_pkg::ST_DIVIDE;
         end
         arcm_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = arcm_pkg::ST_BLEND;
            end
         end
         arcm_pkg::ST_BLEND: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = arcm_pkg::ST_IDLE;
            end
         end
         default: state_in = arcm_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready  = 1'b0;
      div_start  = 1'b0;
      blend_load = 1'b0;
      case (state_ff)
         arcm_pkg::ST_IDLE:   req_ready  = 1'b1;
         arcm_pkg::ST_PREP:   div_start  = !empty_ff;
         arcm_pkg::ST_DIVIDE: ;
         arcm_pkg::ST_BLEND:  blend_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // range tracking and capture of a map request
   always_comb begin
      range_low_in  = range_low_ff;
      range_high_in = range_high_ff;
      range_seen_in = range_seen_ff;
      sample_in     = sample_ff;
      empty_in      = empty_ff;
      if (req_xfer) begin
         case (req_data.req_type)
            arcm_pkg::REQ_CLEAR: begin
               range_low_in  = '0;
               range_high_in = '0;
               range_seen_in = 1'b0;
            end
            arcm_pkg::REQ_WIDEN: begin
               // first sample sets both bounds
               if (!range_seen_ff) begin
                  range_low_in  = samp;
                  range_high_in = samp;
                  range_seen_in = 1'b1;
               end else begin
                  if (samp < range_low_ff) begin
                     range_low_in = samp;
                  end
                  if (samp > range_high_ff) begin
                     range_high_in = samp;
                  end
               end
            end
            arcm_pkg::REQ_MAP: begin
               sample_in = samp;
               empty_in  = !range_seen_ff || (range_low_ff >= range_high_ff);
            end
            default: ;
         endcase
      end
   end

   // clamp into the range and scale to palette steps with 8 fraction bits
   always_comb begin
      clamped = sample_ff;
      if (sample_ff < range_low_ff) begin
         clamped = range_low_ff;
      end else if (sample_ff > range_high_ff) begin
         clamped = range_high_ff;
      end
   end

   assign diff = clamped - range_low_ff;
   assign span = range_high_ff - range_low_ff;
   assign num  = {(SAMPLE_BITS + MUL_BITS)'(diff) *
                  (SAMPLE_BITS + MUL_BITS)'(PALETTE_SIZE - 1), 8'd0};

   // divider: position = num / span
   arcm_div #(
      .DEN_BITS (SAMPLE_BITS),
      .QUO_BITS (QUO_BITS)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (num[QUO_BITS+SAMPLE_BITS-1:0]),
      .denominator (span),
      .done        (div_done),
      .quotient    (position)
   );

   arcm_blend #(
      .PALETTE_SIZE (PALETTE_SIZE),
      .QUO_BITS     (QUO_BITS)
   ) u_blend (
      .position    (position),
      .range_empty (empty_ff),
      .result      (blend_out)
   );

   // output register parts the result side from the sequencer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (blend_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = blend_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= arcm_pkg::ST_IDLE;
         range_low_ff  <= '0;
         range_high_ff <= '0;
         range_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         range_low_ff  <= range_low_in;
         range_high_ff <= range_high_in;
         range_seen_ff <= range_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      empty_ff    <= empty_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a tracked range never inverts
   a_range_order: assert property (@(posedge clock) disable iff (reset)
      range_seen_ff |-> range_low_ff <= range_high_ff)
      else $error("range bounds inverted");

   // the divider finishes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == arcm_pkg::ST_DIVIDE)
      else $error("divider result outside divide phase");

   // an empty range never reaches the divider
   a_no_div_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == arcm_pkg::ST_DIVIDE |-> !empty_ff)
      else $error("divide started on empty range");

   // an empty result carries all-zero colour
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.range_empty |->
         rsp_data.red == 8'd0 && rsp_data.green == 8'd0 &&
         rsp_data.blue == 8'd0 && rsp_data.alpha == 8'd0)
      else $error("empty range result not zero");

endmodule

// File: hdl/arcm_div.sv
// restoring radix-2 divider, one quotient bit per cycle
module arcm_div #(
   parameter int DEN_BITS = arcm_pkg::SAMPLE_BITS_DEFAULT,
   parameter int QUO_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [DEN_BITS+QUO_BITS-1:0] numerator,
   input  logic [DEN_BITS-1:0]          denominator,
   output logic                         done,
   output logic [QUO_BITS-1:0]          quotient
);

   localparam int CNT_BITS = $clog2(QUO_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [QUO_BITS-1:0] sh_ff, sh_in;
   logic [QUO_BITS-1:0] quo_ff, quo_in;
   logic [DEN_BITS:0]   trial;
   logic                fits;

   // partial remainder stays below the divisor
   assign trial = {rem_ff, sh_ff[QUO_BITS-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      sh_in   = sh_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(QUO_BITS);
         rem_in  = numerator[DEN_BITS+QUO_BITS-1:QUO_BITS];
         sh_in   = numerator[QUO_BITS-1:0];
         den_in  = denominator;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_BITS'(trial - {1'b0, den_ff}) : DEN_BITS'(trial);
         sh_in  = {sh_ff[QUO_BITS-2:0], 1'b0};
         quo_in = {quo_ff[QUO_BITS-2:0], fits};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      sh_ff  <= sh_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: hdl/arcm_blend.sv
// palette lookup and linear blend of two neighbouring entries
module arcm_blend #(
   parameter int PALETTE_SIZE = arcm_pkg::PALETTE_SIZE_DEFAULT,
   parameter int QUO_BITS     = 12
) (
   input  logic [QUO_BITS-1:0]   position,
   input  logic                  range_empty,
   output arcm_pkg::rsp_item_type result
);

   localparam logic [arcm_pkg::ENTRY_BITS-1:0] TOP_ENTRY =
      arcm_pkg::ENTRY_BITS'(PALETTE_SIZE - 1);

   logic [arcm_pkg::ENTRY_BITS-1:0] lo_full;
   logic [arcm_pkg::ENTRY_BITS-1:0] lo_idx;
   logic [arcm_pkg::ENTRY_BITS-1:0] hi_idx;
   logic [7:0]                      frac;
   arcm_pkg::color_type             ca;
   arcm_pkg::color_type             cb;

   function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] f);
      logic [15:0] v;
      v = 16'(a) * 16'(9'd256 - {1'b0, f}) + 16'(b) * 16'(f);
      return v[15:8];
   endfunction

   always_comb begin
      lo_full = arcm_pkg::ENTRY_BITS'(position >> 8);
      if (lo_full >= TOP_ENTRY) begin
         lo_idx = TOP_ENTRY;
         frac   = 8'd0;
         hi_idx = TOP_ENTRY;
      end else begin
         lo_idx = lo_full;
         frac   = position[7:0];
         hi_idx = lo_full + arcm_pkg::ENTRY_BITS'(1);
      end
   end

   assign ca = arcm_pkg::palette_entry(lo_idx);
   assign cb = arcm_pkg::palette_entry(hi_idx);

   always_comb begin
      if (range_empty) begin
         result             = '0;
         result.range_empty = 1'b1;
      end else begin
         result.red         = mix(ca.red,   cb.red,   frac);
         result.green       = mix(ca.green, cb.green, frac);
         result.blue        = mix(ca.blue,  cb.blue,  frac);
         result.alpha       = mix(ca.alpha, cb.alpha, frac);
         result.range_empty = 1'b0;
      end
   end

endmodule
